// ===== rtl/sqtw_pkg.sv =====
`default_nettype none

package sqtw_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ID_BITS_DEF    = 8;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // Fixed port widths
  localparam int unsigned TID_W  = 8;
  localparam int unsigned DUR_W  = 32;
  localparam int unsigned KIND_W = 2;

  // Result codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED = 2'd0,
    KIND_ZERO     = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_WOKEN    = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLEEP,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input word, reset scan pointers
    logic sleep;   // resolve a sleep request
    logic scan;    // one step of the tick sweep
    logic finish;  // close the sweep: new count, flush the held wake
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/sleep_queue_tick_waker_unit.sv =====
// Sleep queue with tick wake-up.
// Command channel: a word is taken on a rising edge with start high and
// busy low. opcode_i 0 puts thread_id_i to sleep for sleep_ticks_i ticks,
// opcode_i 1 is one timer tick.
// Result channel: strobe_o marks one result word (kind_o, woken_id_o, last_o)
// for exactly one cycle; the receiver cannot stall, so none is ever held.
// A sleep word gives one result, registered in the SLEEP state after it is
// taken; busy is high for one cycle meanwhile, so the next word waits.
// A tick sweeps the table through a single memory read port, one entry a
// cycle, in the SCAN state and then the FLUSH state, with busy high
// throughout; woken threads appear in insertion order, the final
// one with last_o set. A tick that wakes nothing gives no result.
// Survivors are packed back to the head of the table during the same sweep.
// Reset empties the table and drops any result in flight; no clearing pass
// is needed, the entry count alone marks what is held.
`default_nettype none

module sleep_queue_tick_waker_unit #(
  parameter int unsigned DEPTH      = sqtw_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS    = sqtw_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = sqtw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        opcode_i,
  input  wire logic [sqtw_pkg::TID_W-1:0]  thread_id_i,
  input  wire logic [sqtw_pkg::DUR_W-1:0]  sleep_ticks_i,
  output logic                             strobe_o,
  output logic [sqtw_pkg::KIND_W-1:0]      kind_o,
  output logic [sqtw_pkg::TID_W-1:0]       woken_id_o,
  output logic                             last_o
);

  sqtw_pkg::cmd_t    cmd;
  sqtw_pkg::status_t status;

  sqtw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .tick_i   (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  sqtw_dp #(
    .DEPTH      (DEPTH),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .thread_id_i   (thread_id_i),
    .sleep_ticks_i (sleep_ticks_i),
    .strobe_o      (strobe_o),
    .kind_o        (kind_o),
    .woken_id_o    (woken_id_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sqtw_ctrl.sv =====
`default_nettype none

module sqtw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              tick_i,
  input  wire sqtw_pkg::status_t status_i,
  output sqtw_pkg::cmd_t         cmd_o,
  output logic                   busy_o
);

  sqtw_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sqtw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      sqtw_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = tick_i ? sqtw_pkg::ST_SCAN : sqtw_pkg::ST_SLEEP;
        end
      end
      sqtw_pkg::ST_SLEEP: begin
        cmd_o.sleep = 1'b1;
        state_d     = sqtw_pkg::ST_IDLE;
      end
      sqtw_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = sqtw_pkg::ST_FLUSH;
        end
      end
      sqtw_pkg::ST_FLUSH: begin
        cmd_o.finish = 1'b1;
        state_d      = sqtw_pkg::ST_IDLE;
      end
      default: begin
        state_d = sqtw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sqtw_dp.sv =====
`default_nettype none

module sqtw_dp #(
  parameter int unsigned DEPTH      = sqtw_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS    = sqtw_pkg::ID_BITS_DEF,
  parameter int unsigned COUNT_BITS = sqtw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sqtw_pkg::cmd_t              cmd_i,
  output sqtw_pkg::status_t                status_o,
  input  wire logic [sqtw_pkg::TID_W-1:0]  thread_id_i,
  input  wire logic [sqtw_pkg::DUR_W-1:0]  sleep_ticks_i,
  output logic                             strobe_o,
  output logic [sqtw_pkg::KIND_W-1:0]      kind_o,
  output logic [sqtw_pkg::TID_W-1:0]       woken_id_o,
  output logic                             last_o
);

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W  = ID_BITS + 2 * COUNT_BITS;
  localparam int unsigned WIDE_W = (COUNT_BITS > sqtw_pkg::DUR_W) ? COUNT_BITS
                                                                  : sqtw_pkg::DUR_W;

  // Entry store: {thread, elapsed, target}
  logic [ENT_W-1:0] mem [DEPTH];

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [ENT_W-1:0] mem_wd;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data_q;

  // Control registers
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [CNT_W-1:0] wr_ptr_q, wr_ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic             pend_q, pend_d;
  logic             strobe_q, strobe_d;

  // Payload registers
  logic [sqtw_pkg::TID_W-1:0]  tid_q, tid_d;
  logic [sqtw_pkg::DUR_W-1:0]  dur_q, dur_d;
  logic [ID_BITS-1:0]          pend_id_q, pend_id_d;
  logic [sqtw_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [sqtw_pkg::TID_W-1:0]  id_q, id_d;
  logic                        last_q, last_d;

  // Sweep helpers
  logic                  issue;
  logic                  full;
  logic [WIDE_W-1:0]     dur_wide;
  logic [COUNT_BITS-1:0] target_new;
  logic [ID_BITS-1:0]    rd_thread;
  logic [COUNT_BITS-1:0] rd_elapsed;
  logic [COUNT_BITS-1:0] rd_target;
  logic [COUNT_BITS-1:0] el_inc;
  logic                  expired;

  assign issue      = (scan_cnt_q < count_q);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign dur_wide   = WIDE_W'(dur_q);
  assign target_new = (dur_wide > WIDE_W'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                               : dur_wide[COUNT_BITS-1:0];

  assign rd_target  = rd_data_q[COUNT_BITS-1:0];
  assign rd_elapsed = rd_data_q[2*COUNT_BITS-1:COUNT_BITS];
  assign rd_thread  = rd_data_q[ENT_W-1:2*COUNT_BITS];
  // Saturating increment, then the expiry compare
  assign el_inc     = (rd_elapsed == {COUNT_BITS{1'b1}}) ? rd_elapsed
                                                         : rd_elapsed + COUNT_BITS'(1);
  assign expired    = (el_inc >= rd_target);

  assign status_o.scan_done = !issue && !rd_vld_q;

  // Next-state logic
  always_comb begin
    count_d    = count_q;
    scan_cnt_d = scan_cnt_q;
    wr_ptr_d   = wr_ptr_q;
    rd_vld_d   = 1'b0;
    pend_d     = pend_q;
    strobe_d   = 1'b0;
    tid_d      = tid_q;
    dur_d      = dur_q;
    pend_id_d  = pend_id_q;
    kind_d     = kind_q;
    id_d       = id_q;
    last_d     = last_q;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;

    if (cmd_i.load) begin
      tid_d      = thread_id_i;
      dur_d      = sleep_ticks_i;
      scan_cnt_d = '0;
      wr_ptr_d   = '0;
      pend_d     = 1'b0;
    end

    // Sleep request: one result word, append at the tail unless zero length or full
    if (cmd_i.sleep) begin
      strobe_d = 1'b1;
      id_d     = tid_q;
      last_d   = 1'b1;
      if (dur_q == '0) begin
        kind_d = sqtw_pkg::KIND_ZERO;
      end else if (full) begin
        kind_d = sqtw_pkg::KIND_FULL;
      end else begin
        kind_d  = sqtw_pkg::KIND_INSERTED;
        mem_we  = 1'b1;
        mem_wa  = count_q[IDX_W-1:0];
        mem_wd  = {ID_BITS'(tid_q), {COUNT_BITS{1'b0}}, target_new};
        count_d = count_q + CNT_W'(1);
      end
    end

    // Tick sweep: read one entry a cycle, keep survivors packed at wr_ptr
    if (cmd_i.scan) begin
      if (issue) begin
        rd_en      = 1'b1;
        rd_addr    = scan_cnt_q[IDX_W-1:0];
        scan_cnt_d = scan_cnt_q + CNT_W'(1);
        rd_vld_d   = 1'b1;
      end
      if (rd_vld_q) begin
        if (expired) begin
          // hold each wake back until the next one or the end of sweep so the final one can carry last
          if (pend_q) begin
            strobe_d = 1'b1;
            kind_d   = sqtw_pkg::KIND_WOKEN;
            id_d     = sqtw_pkg::TID_W'(pend_id_q);
            last_d   = 1'b0;
          end
          pend_d    = 1'b1;
          pend_id_d = rd_thread;
        end else begin
          mem_we   = 1'b1;
          mem_wa   = wr_ptr_q[IDX_W-1:0];
          mem_wd   = {rd_thread, el_inc, rd_target};
          wr_ptr_d = wr_ptr_q + CNT_W'(1);
        end
      end
    end

    // End of sweep
    if (cmd_i.finish) begin
      count_d = wr_ptr_q;
      if (pend_q) begin
        strobe_d = 1'b1;
        kind_d   = sqtw_pkg::KIND_WOKEN;
        id_d     = sqtw_pkg::TID_W'(pend_id_q);
        last_d   = 1'b1;
      end
      pend_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_cnt_q <= '0;
      wr_ptr_q   <= '0;
      rd_vld_q   <= 1'b0;
      pend_q     <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_vld_q   <= rd_vld_d;
      pend_q     <= pend_d;
      strobe_q   <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tid_q     <= tid_d;
    dur_q     <= dur_d;
    pend_id_q <= pend_id_d;
    kind_q    <= kind_d;
    id_q      <= id_d;
    last_q    <= last_d;
  end

  // Entry store write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Entry store read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign woken_id_o = id_q;
  assign last_o     = last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> scan_cnt_q <= count_q)
    else $error("sweep read past the table");

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> wr_ptr_q <= scan_cnt_q)
    else $error("compaction write overtook the sweep");

  a_sleep_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && kind_q != sqtw_pkg::KIND_WOKEN) |-> last_q)
    else $error("sleep result without last");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !pend_q)
    else $error("held wake survived the end of sweep");

endmodule

`default_nettype wire

// ===== tb/sqtw_wake_checker.sv =====
// Watches the command and result channels of the sleep queue, keeps its own
// copy of the table and compares every result word with the oldest one due.
module sqtw_wake_checker #(
  parameter int unsigned SLOTS = sqtw_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic                            opcode_i,
  input  logic [sqtw_pkg::TID_W-1:0]      thread_id_i,
  input  logic [sqtw_pkg::DUR_W-1:0]      sleep_ticks_i,
  input  logic                            strobe_i,
  input  logic [sqtw_pkg::KIND_W-1:0]     kind_i,
  input  logic [sqtw_pkg::TID_W-1:0]      woken_id_i,
  input  logic                            last_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  import sqtw_pkg::*;

  typedef struct {
    kind_e            kind;
    logic [TID_W-1:0] tid;
    logic             last;
  } wake_word_t;

  // Model of the sleeping table: slots 0..held-1 are live, oldest first
  logic [TID_W-1:0] slot_tid     [SLOTS];
  logic [DUR_W-1:0] slot_elapsed [SLOTS];
  logic [DUR_W-1:0] slot_target  [SLOTS];
  int unsigned      held;

  wake_word_t  due_results[$];
  int unsigned mismatches;

  // Push one result word onto the list of words still to arrive
  task automatic expect_word(kind_e kind, logic [TID_W-1:0] tid, logic last);
    wake_word_t w;
    w.kind = kind;
    w.tid  = tid;
    w.last = last;
    due_results.push_back(w);
  endtask

  // Sleep request: append at the tail unless zero length or no room left
  task automatic apply_sleep(logic [TID_W-1:0] tid, logic [DUR_W-1:0] ticks);
    if (ticks == '0) begin
      expect_word(KIND_ZERO, tid, 1'b1);
    end else if (held >= SLOTS) begin
      expect_word(KIND_FULL, tid, 1'b1);
    end else begin
      slot_tid[held]     = tid;
      slot_elapsed[held] = '0;
      slot_target[held]  = ticks;
      held++;
      expect_word(KIND_INSERTED, tid, 1'b1);
    end
  endtask

  // Timer tick: age every slot, wake the expired ones in order, pack the rest
  task automatic apply_tick();
    logic [TID_W-1:0] woke [SLOTS];
    int unsigned      n_woke;
    int unsigned      keep;
    n_woke = 0;
    keep   = 0;
    for (int unsigned i = 0; i < held; i++) begin
      if (slot_elapsed[i] != '1) slot_elapsed[i]++;
      if (slot_elapsed[i] >= slot_target[i]) begin
        woke[n_woke] = slot_tid[i];
        n_woke++;
      end else begin
        slot_tid[keep]     = slot_tid[i];
        slot_elapsed[keep] = slot_elapsed[i];
        slot_target[keep]  = slot_target[i];
        keep++;
      end
    end
    held = keep;
    for (int unsigned k = 0; k < n_woke; k++)
      expect_word(KIND_WOKEN, woke[k], k == n_woke - 1);
  endtask

  // Compare one result word with the oldest one due
  task automatic check_word();
    wake_word_t w;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result word: kind %0d id %0d last %0d",
               $time, kind_i, woken_id_i, last_i);
      mismatches++;
    end else begin
      w = due_results.pop_front();
      if (kind_i !== w.kind) begin
        $display("%0t: kind mismatch: expected %0d actual %0d", $time, w.kind, kind_i);
        mismatches++;
      end
      if (woken_id_i !== w.tid) begin
        $display("%0t: woken_id mismatch: expected %0d actual %0d",
                 $time, w.tid, woken_id_i);
        mismatches++;
      end
      if (last_i !== w.last) begin
        $display("%0t: last mismatch: expected %0d actual %0d", $time, w.last, last_i);
        mismatches++;
      end
    end
  endtask

  // Results first: a word arriving on the same edge belongs to an older command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held        = 0;
      mismatches  = 0;
      due_results.delete();
      pending_o  <= 0;
      errors_o   <= 0;
    end else begin
      if (strobe_i === 1'b1) check_word();
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        if (opcode_i) apply_tick();
        else apply_sleep(thread_id_i, sleep_ticks_i);
      end
      pending_o <= due_results.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ===== tb/tb_sleep_queue_tick_waker_unit.sv =====
// Drives sleep and tick words into the sleep queue with random gaps; the
// checker alongside does the prediction and comparison.
module tb_sleep_queue_tick_waker_unit;
  import sqtw_pkg::*;

  localparam int unsigned SLOTS      = DEPTH_DEF;
  localparam int unsigned RAND_WORDS = 450;
  localparam logic        OP_SLEEP   = 1'b0;
  localparam logic        OP_TICK    = 1'b1;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic               opcode_i      = 1'b0;
  logic [TID_W-1:0]   thread_id_i   = '0;
  logic [DUR_W-1:0]   sleep_ticks_i = '0;
  logic               strobe_o;
  logic [KIND_W-1:0]  kind_o;
  logic [TID_W-1:0]   woken_id_o;
  logic               last_o;
  int unsigned        pending;
  int unsigned        errors;
  bit                 no_gaps;

  sleep_queue_tick_waker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .thread_id_i   (thread_id_i),
    .sleep_ticks_i (sleep_ticks_i),
    .strobe_o      (strobe_o),
    .kind_o        (kind_o),
    .woken_id_o    (woken_id_o),
    .last_o        (last_o)
  );

  sqtw_wake_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .opcode_i      (opcode_i),
    .thread_id_i   (thread_id_i),
    .sleep_ticks_i (sleep_ticks_i),
    .strobe_i      (strobe_o),
    .kind_i        (kind_o),
    .woken_id_i    (woken_id_o),
    .last_i        (last_o),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  always #5 clk_i = ~clk_i;

  // Mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(99);
    if (no_gaps || sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word until taken, then idle for a randomly picked gap with junk fields
  task automatic send_word(logic op, logic [TID_W-1:0] tid, logic [DUR_W-1:0] ticks);
    int unsigned gap;
    start         <= 1'b1;
    opcode_i      <= op;
    thread_id_i   <= tid;
    sleep_ticks_i <= ticks;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start         <= 1'b0;
      opcode_i      <= 1'($urandom_range(1));
      thread_id_i   <= TID_W'($urandom_range(255));
      sleep_ticks_i <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random word: short sleeps outnumber ticks so the table fills now and then
  task automatic send_random_word();
    int unsigned      sel;
    logic [DUR_W-1:0] ticks;
    sel = $urandom_range(99);
    if (sel < 42) begin
      send_word(OP_TICK, TID_W'($urandom_range(255)), $urandom());
    end else begin
      sel = $urandom_range(99);
      if (sel < 6) ticks = '0;
      else if (sel < 7) ticks = $urandom();
      else if (sel < 20) ticks = $urandom_range(13, 40);
      else ticks = $urandom_range(1, 12);
      send_word(OP_SLEEP, TID_W'($urandom_range(255)), ticks);
    end
  endtask

  initial begin
    no_gaps = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: quiet tick, zero length, longest sleep, repeated thread
    send_word(OP_TICK,  8'h00, '0);
    send_word(OP_SLEEP, 8'h00, '0);
    send_word(OP_SLEEP, 8'hFF, '1);
    send_word(OP_SLEEP, 8'h5A, 32'd1);
    send_word(OP_SLEEP, 8'h5A, 32'd2);
    send_word(OP_TICK,  8'hFF, '1);
    send_word(OP_TICK,  8'hA5, 32'h5555_5555);

    // Fill the table, hit the full case, then wake a batch in one tick
    for (int unsigned k = 1; k < SLOTS; k++)
      send_word(OP_SLEEP, 8'(k * 17), 32'(1 + k % 3));
    send_word(OP_SLEEP, 8'h81, 32'd1);
    send_word(OP_TICK,  8'h00, '0);

    // Random phase with runs of back to back words
    for (int unsigned n = 0; n < RAND_WORDS; n++) begin
      if ($urandom_range(29) == 0) no_gaps = !no_gaps;
      send_random_word();
    end
    start <= 1'b0;

    // Drain: let the checker catch up, then leave room for any stray word
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SLOTS + 24) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
